// ===== src/tlsm_pkg.sv =====
`timescale 1ns / 1ps

package tlsm_pkg;

    // Fixed field widths and the default list depth
    localparam int VALUE_W            = 32;
    localparam int CMD_W              = 2;
    localparam int DEFAULT_LIST_DEPTH = 32;

    // Request command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND_A = 2'd0,
        CMD_APPEND_B = 2'd1,
        CMD_MERGE    = 2'd2,
        CMD_CONCAT   = 2'd3
    } cmd_t;

    // One emitted result, passed from the sequencer to the output stage
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      from_list;
        logic                      last;
    } result_t;

endpackage

// ===== src/tlsm_list_mem.sv =====
`timescale 1ns / 1ps

module tlsm_list_mem
    import tlsm_pkg::*;
#(
    parameter int DEPTH  = DEFAULT_LIST_DEPTH,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [VALUE_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [VALUE_W-1:0] rd_data
);

    logic signed [VALUE_W-1:0] mem [DEPTH];

    // Single write port, registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== src/tlsm_out_stage.sv =====
`timescale 1ns / 1ps

module tlsm_out_stage
    import tlsm_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  result_t                   res,
    output logic                      ready,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      from_list,
    output logic                      last
);

    logic    valid_reg;
    result_t res_reg;

    // Space for a new result when empty or when the held one leaves now
    assign ready = !valid_reg || !out_stall;

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ready)
        begin
            valid_reg <= load;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (ready && load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_value = res_reg.value;
    assign from_list = res_reg.from_list;
    assign last      = res_reg.last;

endmodule

// ===== src/two_list_sorted_merge.sv =====
`timescale 1ns / 1ps

// Two-list sorted merge. Append requests (command 0 to list A, 1 to list B)
// are dropped when the list already holds LIST_DEPTH values. A merge
// request (2) emits every stored value in signed ascending merge order, ties
// going to B; a concatenate request (3) emits A then B. The final result
// carries last, both lists are then empty, and an emit with both lists empty
// gives no result. An emit first reads both list heads from the memories,
// then gives one result per cycle while the output does not stall, each
// result fetching the next head of the list it came from through that list's
// single read port. No request is taken during an emit; the last result may
// still wait in the output register while the next request is accepted.
module two_list_sorted_merge
    import tlsm_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [CMD_W-1:0]          command,
    input  logic signed [VALUE_W-1:0] value,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] out_value,
    output logic                      from_list,
    output logic                      last
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  a_cnt_reg, a_cnt_next;
    logic [CNT_W-1:0]  b_cnt_reg, b_cnt_next;
    logic [CNT_W-1:0]  ia_reg, ia_next;
    logic [CNT_W-1:0]  ib_reg, ib_next;
    logic              merge_reg, merge_next;

    logic              in_fire;
    logic              wr_a, wr_b;
    logic              rd_a, rd_b;
    logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;
    logic signed [VALUE_W-1:0] head_a, head_b;

    logic              out_ready;
    logic              step;
    result_t           res;
    logic              a_left, b_left, take_a;
    logic [CNT_W-1:0]  ia_inc, ib_inc;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;

    // List stores
    tlsm_list_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_a (
        .clk     (clk),
        .wr_en   (wr_a),
        .wr_addr (a_cnt_reg[ADDR_W-1:0]),
        .wr_data (value),
        .rd_en   (rd_a),
        .rd_addr (rd_addr_a),
        .rd_data (head_a)
    );

    tlsm_list_mem #(
        .DEPTH  (LIST_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem_b (
        .clk     (clk),
        .wr_en   (wr_b),
        .wr_addr (b_cnt_reg[ADDR_W-1:0]),
        .wr_data (value),
        .rd_en   (rd_b),
        .rd_addr (rd_addr_b),
        .rd_data (head_b)
    );

    // Selection of the next result from the two heads
    assign a_left = (ia_reg < a_cnt_reg);
    assign b_left = (ib_reg < b_cnt_reg);
    assign take_a = a_left && (!merge_reg || !b_left || (head_a < head_b));
    assign ia_inc = ia_reg + CNT_W'(1);
    assign ib_inc = ib_reg + CNT_W'(1);

    always_comb
    begin
        res.value     = take_a ? head_a : head_b;
        res.from_list = !take_a;
        res.last      = take_a ? ((ia_inc == a_cnt_reg) && !b_left)
                               : ((ib_inc == b_cnt_reg) && !a_left);
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        ia_next    = ia_reg;
        ib_next    = ib_reg;
        merge_next = merge_reg;
        wr_a       = 1'b0;
        wr_b       = 1'b0;
        rd_a       = 1'b0;
        rd_b       = 1'b0;
        rd_addr_a  = '0;
        rd_addr_b  = '0;
        step       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (command == CMD_APPEND_A)
                    begin
                        if (a_cnt_reg < CNT_W'(LIST_DEPTH))
                        begin
                            wr_a       = 1'b1;
                            a_cnt_next = a_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (command == CMD_APPEND_B)
                    begin
                        if (b_cnt_reg < CNT_W'(LIST_DEPTH))
                        begin
                            wr_b       = 1'b1;
                            b_cnt_next = b_cnt_reg + CNT_W'(1);
                        end
                    end
                    else if (command inside {CMD_MERGE, CMD_CONCAT})
                    begin
                        // Fetch both heads; nothing to do if both are empty
                        if ((a_cnt_reg != '0) || (b_cnt_reg != '0))
                        begin
                            rd_a       = 1'b1;
                            rd_b       = 1'b1;
                            ia_next    = '0;
                            ib_next    = '0;
                            merge_next = (command == CMD_MERGE);
                            state_next = ST_RUN;
                        end
                    end
                end
            end
            ST_RUN:
            begin
                if (out_ready)
                begin
                    step = 1'b1;
                    if (take_a)
                    begin
                        ia_next   = ia_inc;
                        rd_a      = 1'b1;
                        rd_addr_a = ia_inc[ADDR_W-1:0];
                    end
                    else
                    begin
                        ib_next   = ib_inc;
                        rd_b      = 1'b1;
                        rd_addr_b = ib_inc[ADDR_W-1:0];
                    end
                    if (res.last)
                    begin
                        a_cnt_next = '0;
                        b_cnt_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
            ia_reg    <= '0;
            ib_reg    <= '0;
            merge_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
            ia_reg    <= ia_next;
            ib_reg    <= ib_next;
            merge_reg <= merge_next;
        end
    end

    // Output register
    tlsm_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res       (res),
        .ready     (out_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_value (out_value),
        .from_list (from_list),
        .last      (last)
    );

`ifndef SYNTH
    // Fill levels never pass the list depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (a_cnt_reg <= CNT_W'(LIST_DEPTH)) && (b_cnt_reg <= CNT_W'(LIST_DEPTH)))
        else $error("list fill level beyond depth");

    // While emitting there is always something left to send
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (a_left || b_left))
        else $error("emit running with both lists exhausted");

    // An emit of non-empty lists blocks further requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (command == CMD_MERGE || command == CMD_CONCAT)
            && ((a_cnt_reg != '0) || (b_cnt_reg != '0))) |=> in_stall)
        else $error("emit did not start");

    // The last result empties both lists and frees the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.last) |=> ((a_cnt_reg == '0) && (b_cnt_reg == '0) && !in_stall))
        else $error("lists not emptied after last result");
`endif

endmodule
